@@ sv/bounded_deque_with_key_search_macros.svh @@
// Assertion macros shared by the deque RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BOUNDED_DEQUE_WITH_KEY_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_KEY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define BDQ_ASSERT_HOLD(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("bdq: invariant violated");
`define BDQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdq: implication violated");
`else
`define BDQ_ASSERT_HOLD(label, expr)
`define BDQ_ASSERT_IMPL(label, ante, cons)
`endif

`endif

@@ sv/bdq_pkg.sv @@
// Types and constants for the bounded deque with key search.
// No dependencies; imported by every module of the block but bdq_ram.
package bdq_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned REC_W  = 64;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned CNT_W  = 7;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_FIND       = 3'd5;

  // depth of the command queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_READ,
    OP_FIND,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  rec_key;
    logic [REC_W-1:0]  rec_payload;
    logic [POS_W-1:0]  position;
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [KEY_W-1:0]  out_key;
    logic [REC_W-1:0]  out_payload;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
  } result_t;

  // decoded request as it travels through the queue
  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] payload;
    logic             pos_valid;
    logic [POS_W-1:0] pos_m1;
  } job_t;

endpackage

@@ sv/bdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bdq_queue.sv @@
// Short FIFO of decoded jobs between the front and back of the deque.
// Depends on bdq_pkg.
module bdq_queue import bdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t job_o
);

  localparam int unsigned QAW = $clog2(Q_DEPTH);
  localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

  job_t           slot_q [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign full_o  = (fill_q == QCW'(Q_DEPTH));
  assign valid_o = (fill_q != '0);
  assign job_o   = slot_q[rd_ptr_q];

endmodule

@@ sv/bdq_front.sv @@
// Request front end: takes a command transfer and decodes it into a job.
// Depends on bdq_pkg.
module bdq_front import bdq_pkg::*; (
  input  logic start,
  input  cmd_t cmd_i,
  input  logic q_full_i,
  output logic busy,
  output logic push_o,
  output job_t job_o
);

  always_comb begin
    job_o.key       = cmd_i.rec_key;
    job_o.payload   = cmd_i.rec_payload;
    job_o.pos_valid = (cmd_i.position != '0);
    job_o.pos_m1    = cmd_i.position - 1'b1;
    unique case (cmd_i.func)
      FUNC_PUSH_FRONT: job_o.op = OP_PUSH_FRONT;
      FUNC_PUSH_BACK:  job_o.op = OP_PUSH_BACK;
      FUNC_POP_FRONT:  job_o.op = OP_POP_FRONT;
      FUNC_POP_BACK:   job_o.op = OP_POP_BACK;
      FUNC_READ:       job_o.op = OP_READ;
      FUNC_FIND:       job_o.op = OP_FIND;
      default:         job_o.op = OP_NOP;
    endcase
  end

  assign busy   = q_full_i;
  assign push_o = start && !q_full_i;

endmodule

@@ sv/bdq_back.sv @@
// Execution back end: ring pointers, record RAM and the linear key scan.
// Depends on bdq_pkg, bdq_ram and the assertion macro header.
`include "bounded_deque_with_key_search_macros.svh"
module bdq_back import bdq_pkg::*; #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned RECORD_BITS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  job_t    job_i,
  output logic    q_pop_o,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned RW   = RECORD_BITS;
  localparam int unsigned CMPW = (POS_W > CW) ? POS_W : CW;
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] issue_q, issue_d;
  logic          rd_vld_q, rd_vld_d;
  logic          rd_last_q, rd_last_d;
  logic [KW-1:0] find_key_q, find_key_d;
  logic          done_q, done_d;
  result_t       res_q, res_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [KW+RW-1:0] ram_wdata;
  logic [KW+RW-1:0] ram_rdata;
  logic [KW-1:0]  rd_key;
  logic [RW-1:0]  rd_payload;
  logic [AW-1:0]  head_dec;

  // head plus offset, both below DEPTH, folded into the ring
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  assign rd_key     = ram_rdata[KW+RW-1:RW];
  assign rd_payload = ram_rdata[RW-1:0];
  assign head_dec   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    issue_d    = issue_q;
    rd_vld_d   = 1'b0;
    rd_last_d  = 1'b0;
    find_key_d = find_key_q;
    done_d     = 1'b0;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = head_q;
    ram_raddr  = head_q;
    ram_wdata  = {KW'(job_i.key), RW'(job_i.payload)};
    res_d      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          done_d  = 1'b1;
          unique case (job_i.op)
            OP_PUSH_FRONT: begin
              if (count_q != DEPTH_C) begin
                head_d    = head_dec;
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                count_d   = count_q + 1'b1;
                res_d.ok  = 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (count_q != DEPTH_C) begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(head_q, count_q[AW-1:0]);
                count_d   = count_q + 1'b1;
                res_d.ok  = 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count_q != '0) begin
                head_d   = ring_add(head_q, AW'(1));
                count_d  = count_q - 1'b1;
                res_d.ok = 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (count_q != '0) begin
                count_d  = count_q - 1'b1;
                res_d.ok = 1'b1;
              end
            end
            OP_READ: begin
              if (job_i.pos_valid && (CMPW'(job_i.pos_m1) < CMPW'(count_q))) begin
                ram_raddr = ring_add(head_q, job_i.pos_m1[AW-1:0]);
                done_d    = 1'b0;
                state_d   = ST_READ;
              end
            end
            OP_FIND: begin
              if (count_q != '0) begin
                find_key_d = KW'(job_i.key);
                issue_d    = '0;
                done_d     = 1'b0;
                state_d    = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        done_d            = 1'b1;
        res_d.ok          = 1'b1;
        res_d.out_key     = KEY_W'(rd_key);
        res_d.out_payload = REC_W'(rd_payload);
        state_d           = ST_IDLE;
      end
      ST_SCAN: begin
        // one entry issued per cycle, compared when its data returns
        priority if (rd_vld_q && (rd_key == find_key_q)) begin
          done_d            = 1'b1;
          res_d.ok          = 1'b1;
          res_d.out_key     = KEY_W'(rd_key);
          res_d.out_payload = REC_W'(rd_payload);
          state_d           = ST_IDLE;
        end else if (rd_vld_q && rd_last_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (issue_q < count_q) begin
          ram_raddr = ring_add(head_q, issue_q[AW-1:0]);
          rd_vld_d  = 1'b1;
          rd_last_d = (issue_q == count_q - 1'b1);
          issue_d   = issue_q + 1'b1;
        end else begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    res_d.entry_count = CNT_W'(count_d);
    res_d.is_empty    = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    find_key_q <= find_key_d;
    res_q      <= res_d;
  end

  bdq_ram #(
    .WIDTH(KW + RW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

  `BDQ_ASSERT_HOLD(a_count_bound, count_q <= DEPTH_C)
  `BDQ_ASSERT_HOLD(a_head_bound, {1'b0, head_q} < DEPTH_X)
  `BDQ_ASSERT_IMPL(a_done_in_idle, done_q, state_q == ST_IDLE)
  `BDQ_ASSERT_IMPL(a_fail_clears, done_q && !res_q.ok, res_q.out_key == '0 && res_q.out_payload == '0)
  `BDQ_ASSERT_IMPL(a_scan_issued, rd_vld_q, issue_q != '0 && state_q == ST_SCAN)

endmodule

@@ sv/bounded_deque_with_key_search.sv @@
// Top level of the bounded deque of keyed records with key search.
// Depends on bdq_pkg, bdq_front, bdq_queue and bdq_back.
//
// Usage:
//   A request transfers when start is high and busy is low; cmd_i holds the
//   function code, key, payload and 1-based position. Each request gives
//   exactly one result: done_o is high for one cycle with result_o valid.
//   Results come back in request order and cannot be held off.
//   Requests pass through a two-entry queue, so two may be taken while an
//   earlier one is still executing; busy is high while the queue is full.
//   A request is written into the queue, taken from it by the back end, and
//   its result is registered onto done_o. A position read also waits for
//   the registered RAM read data, and a key search reads one stored record
//   per cycle from the single read port of the record RAM, stopping at the
//   first match or after the last stored record. Inserts, removals and
//   failed requests run one per cycle while the back end is idle; a position
//   read or a key search holds the back end until its result is registered.
//   Reset empties the store (head and count cleared); record contents are
//   left as they are and are never read before being written.
module bounded_deque_with_key_search import bdq_pkg::*; #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned RECORD_BITS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    done_o,
  output result_t result_o
);

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t job_in;
  job_t job_out;

  bdq_front u_front (
    .start   (start),
    .cmd_i   (cmd_i),
    .q_full_i(q_full),
    .busy    (busy),
    .push_o  (q_push),
    .job_o   (job_in)
  );

  bdq_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (job_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .job_o  (job_out)
  );

  bdq_back #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .RECORD_BITS(RECORD_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .job_i    (job_out),
    .q_pop_o  (q_pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
